### rtl/qpn_pkg.sv
// Shared types and constants of the normalized quaternion product core.
package qpn_pkg;

    localparam int QW   = 16;  // input and output component width
    localparam int PW   = 32;  // one partial product
    localparam int SW   = 34;  // signed sum of four products
    localparam int MW   = 33;  // magnitude of one sum
    localparam int NW   = 31;  // magnitude after normalization, at most 2^30
    localparam int SQW  = 62;  // square of a normalized magnitude
    localparam int SSW  = 63;  // sum of four squares
    localparam int RTW  = 32;  // integer square root of the sum
    localparam int NUMW = 45;  // rounded dividend of one component
    localparam int QTW  = 15;  // quotient, at most 16384

    localparam int SQRT_STAGES = 16;  // two root bits per stage
    localparam int DIV_STAGES  = QTW; // one quotient bit per stage

    localparam int CX = 0;
    localparam int CY = 1;
    localparam int CZ = 2;
    localparam int CW = 3;

    localparam logic [1:0] CMD_MUL  = 2'd0;
    localparam logic [1:0] CMD_CONJ = 2'd1;
    localparam logic [1:0] CMD_YAW  = 2'd2;

    typedef logic [3:0][QW-1:0] t_quat;
    typedef logic [3:0][NW-1:0] t_mags;

    typedef struct packed {
        logic [3:0] neg;    // sign of each component
        logic       zero;   // all components were zero
        logic       blank;  // unused command
    } t_ctl;

    typedef struct packed {
        logic [3:0][QW-1:0] r;
        logic               zero_norm;
    } t_res;

endpackage

### rtl/quaternion_product_normalized_core.sv
// Top level of the normalized quaternion product core with output skid stage.
// Usage:
// The input channel (i_valid, o_ready) carries one beat per item: a command
// and two quaternions a and b in signed Q1.14, vector part first. Command 0
// forms a*b, command 1 forms a times the conjugate of b, command 2 keeps the
// yaw part of a. The result beat on (o_valid, i_ready) is the unit
// quaternion in signed Q1.14 with a zero_norm flag; a zero result gives all
// zeros with the flag set, and the unused command gives zeros without it.
// Throughput is one beat per cycle while o_ready is high. A result passes
// through products, sums and normalization, sixteen square-root stages at
// two root bits each, one dividend stage, fifteen divider stages at one
// quotient bit each, and the output register.
// When the receiver stalls, the pipeline keeps moving until the skid
// register behind the output register fills, then o_ready drops and the
// whole pipeline holds; no beat is lost or repeated. Reset clears all valid
// bits, including those of the output and skid registers; no clearing pass
// is needed.
module quaternion_product_normalized_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_command,
    input  logic signed [15:0] i_a_x,
    input  logic signed [15:0] i_a_y,
    input  logic signed [15:0] i_a_z,
    input  logic signed [15:0] i_a_w,
    input  logic signed [15:0] i_b_x,
    input  logic signed [15:0] i_b_y,
    input  logic signed [15:0] i_b_z,
    input  logic signed [15:0] i_b_w,
    output logic        o_valid,
    input  logic        i_ready,
    output logic signed [15:0] o_r_x,
    output logic signed [15:0] o_r_y,
    output logic signed [15:0] o_r_z,
    output logic signed [15:0] o_r_w,
    output logic        o_zero_norm
);
    import qpn_pkg::*;

    logic           en;
    t_quat          a, b;
    logic           f_valid, s_valid, d_valid;
    t_ctl           f_ctl, s_ctl;
    t_mags          f_mag, s_mag;
    logic [SSW-1:0] f_sumsq;
    logic [RTW-1:0] s_root;
    t_res           d_res;
    logic           cap;

    logic           r_out_v, r_skid_v;
    t_res           r_out, r_skid;

    assign a = {i_a_w, i_a_z, i_a_y, i_a_x};
    assign b = {i_b_w, i_b_z, i_b_y, i_b_x};

    assign en      = ~r_skid_v;
    assign o_ready = en;
    assign cap     = en & d_valid;

    qpn_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_valid),
        .i_command(i_command),
        .i_a      (a),
        .i_b      (b),
        .o_valid  (f_valid),
        .o_ctl    (f_ctl),
        .o_mag    (f_mag),
        .o_sumsq  (f_sumsq)
    );

    qpn_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_ctl   (f_ctl),
        .i_mag   (f_mag),
        .i_sumsq (f_sumsq),
        .o_valid (s_valid),
        .o_ctl   (s_ctl),
        .o_mag   (s_mag),
        .o_root  (s_root)
    );

    qpn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_valid),
        .i_ctl   (s_ctl),
        .i_mag   (s_mag),
        .i_root  (s_root),
        .o_valid (d_valid),
        .o_res   (d_res)
    );

    // A beat leaving the pipeline goes to the output register when it is free,
    // otherwise into the skid register, which then holds the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || i_ready) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= cap;
            end
        end else if (cap) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || i_ready) begin
            r_out <= r_skid_v ? r_skid : d_res;
        end else if (cap) begin
            r_skid <= d_res;
        end
    end

    assign o_valid     = r_out_v;
    assign o_r_x       = r_out.r[CX];
    assign o_r_y       = r_out.r[CY];
    assign o_r_z       = r_out.r[CZ];
    assign o_r_w       = r_out.r[CW];
    assign o_zero_norm = r_out.zero_norm;

endmodule

### rtl/qpn_front.sv
// Products, command sums, magnitudes, block normalization and sum of squares.
module qpn_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [1:0]    i_command,
    input  qpn_pkg::t_quat i_a,
    input  qpn_pkg::t_quat i_b,
    output logic          o_valid,
    output qpn_pkg::t_ctl o_ctl,
    output qpn_pkg::t_mags o_mag,
    output logic [qpn_pkg::SSW-1:0] o_sumsq
);
    import qpn_pkg::*;

    localparam logic [MW-1:0] LIM_HI = MW'(1 << 30);
    localparam logic [MW-1:0] LIM_LO = MW'(1 << 29);

    logic [7:0] r_v;

    // stage 1: all sixteen products
    logic signed [PW-1:0] r_prod [4][4];
    logic [1:0]           r_cmd1;
    logic [QW-1:0]        r_az1, r_aw1;
    // stage 2: signed sums
    logic signed [SW-1:0] r_q2 [4];
    logic signed [SW-1:0] n_q2 [4];
    logic                 r_blank2, n_blank2;
    // stage 3: magnitudes
    logic [MW-1:0]        r_mag3 [4];
    t_ctl                 r_ctl3;
    // stage 4: largest magnitude
    logic [MW-1:0]        r_mag4 [4];
    logic [MW-1:0]        r_max4;
    t_ctl                 r_ctl4;
    // stage 5: shift amount
    logic [MW-1:0]        r_mag5 [4];
    logic [1:0]           r_rsh5, n_rsh5;
    logic [4:0]           r_lsh5, n_lsh5;
    t_ctl                 r_ctl5;
    // stage 6: normalized magnitudes
    t_mags                r_nm6;
    t_ctl                 r_ctl6;
    // stage 7: squares
    t_mags                r_nm7;
    logic [SQW-1:0]       r_sq7 [4];
    t_ctl                 r_ctl7;
    // stage 8: sum of squares
    t_mags                r_nm8;
    logic [SSW-1:0]       r_ss8;
    t_ctl                 r_ctl8;

    logic signed [SW-1:0] p [4][4];
    logic [MW-1:0]        m01, m23;
    logic [4:0]           msb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[6:0], i_valid};
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                p[i][j] = SW'(r_prod[i][j]);
            end
        end
        n_blank2 = 1'b0;
        for (int i = 0; i < 4; i++) begin
            n_q2[i] = '0;
        end
        unique case (r_cmd1)
            CMD_MUL: begin
                n_q2[CX] = p[CX][CW] + p[CY][CZ] - p[CZ][CY] + p[CW][CX];
                n_q2[CY] = p[CY][CW] - p[CX][CZ] + p[CZ][CX] + p[CW][CY];
                n_q2[CZ] = p[CX][CY] - p[CY][CX] + p[CZ][CW] + p[CW][CZ];
                n_q2[CW] = p[CW][CW] - p[CX][CX] - p[CY][CY] - p[CZ][CZ];
            end
            CMD_CONJ: begin
                n_q2[CX] = p[CX][CW] - p[CY][CZ] + p[CZ][CY] - p[CW][CX];
                n_q2[CY] = p[CX][CZ] + p[CY][CW] - p[CZ][CX] - p[CW][CY];
                n_q2[CZ] = p[CY][CX] - p[CX][CY] + p[CZ][CW] - p[CW][CZ];
                n_q2[CW] = p[CX][CX] + p[CY][CY] + p[CZ][CZ] + p[CW][CW];
            end
            CMD_YAW: begin
                n_q2[CZ] = SW'($signed(r_az1));
                n_q2[CW] = SW'($signed(r_aw1));
            end
            default: begin
                n_blank2 = 1'b1;
            end
        endcase
    end

    always_comb begin
        m01 = (r_mag3[0] > r_mag3[1]) ? r_mag3[0] : r_mag3[1];
        m23 = (r_mag3[2] > r_mag3[3]) ? r_mag3[2] : r_mag3[3];
    end

    // Bring the largest magnitude into [2^29, 2^30].
    always_comb begin
        msb    = '0;
        n_rsh5 = '0;
        n_lsh5 = '0;
        for (int k = 0; k < 29; k++) begin
            if (r_max4[k]) begin
                msb = 5'(k);
            end
        end
        if (r_max4 > LIM_HI) begin
            n_rsh5 = ((r_max4 >> 1) > LIM_HI) ? 2'd2 : 2'd1;
        end else if (r_max4 < LIM_LO) begin
            n_lsh5 = 5'd29 - msb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4; j++) begin
                    r_prod[i][j] <= $signed(i_a[i]) * $signed(i_b[j]);
                end
            end
            r_cmd1 <= i_command;
            r_az1  <= i_a[CZ];
            r_aw1  <= i_a[CW];

            r_q2     <= n_q2;
            r_blank2 <= n_blank2;

            for (int i = 0; i < 4; i++) begin
                r_ctl3.neg[i] <= r_q2[i][SW-1];
                r_mag3[i]     <= MW'(r_q2[i][SW-1] ? -r_q2[i] : r_q2[i]);
            end
            r_ctl3.zero  <= 1'b0;
            r_ctl3.blank <= r_blank2;

            r_mag4 <= r_mag3;
            r_max4 <= (m01 > m23) ? m01 : m23;
            r_ctl4 <= r_ctl3;

            r_mag5 <= r_mag4;
            r_rsh5 <= n_rsh5;
            r_lsh5 <= n_lsh5;
            r_ctl5 <= '{neg: r_ctl4.neg, zero: (r_max4 == '0), blank: r_ctl4.blank};

            for (int i = 0; i < 4; i++) begin
                r_nm6[i] <= NW'((r_rsh5 != '0) ? (r_mag5[i] >> r_rsh5)
                                               : (r_mag5[i] << r_lsh5));
            end
            r_ctl6 <= r_ctl5;

            for (int i = 0; i < 4; i++) begin
                r_sq7[i] <= SQW'(r_nm6[i]) * SQW'(r_nm6[i]);
            end
            r_nm7  <= r_nm6;
            r_ctl7 <= r_ctl6;

            r_ss8  <= (SSW'(r_sq7[0]) + SSW'(r_sq7[1])) + (SSW'(r_sq7[2]) + SSW'(r_sq7[3]));
            r_nm8  <= r_nm7;
            r_ctl8 <= r_ctl7;
        end
    end

    assign o_valid = r_v[7];
    assign o_ctl   = r_ctl8;
    assign o_mag   = r_nm8;
    assign o_sumsq = r_ss8;

endmodule

### rtl/qpn_sqrt.sv
// Pipelined integer square root, two root bits per stage.
module qpn_sqrt (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  qpn_pkg::t_ctl i_ctl,
    input  qpn_pkg::t_mags i_mag,
    input  logic [qpn_pkg::SSW-1:0] i_sumsq,
    output logic          o_valid,
    output qpn_pkg::t_ctl o_ctl,
    output qpn_pkg::t_mags o_mag,
    output logic [qpn_pkg::RTW-1:0] o_root
);
    import qpn_pkg::*;

    logic [SQRT_STAGES-1:0] r_v;
    logic [63:0]     r_rad  [SQRT_STAGES];
    logic [RTW+1:0]  r_rem  [SQRT_STAGES];
    logic [RTW-1:0]  r_root [SQRT_STAGES];
    t_mags           r_mag  [SQRT_STAGES];
    t_ctl            r_ctl  [SQRT_STAGES];

    logic [63:0]     n_rad  [SQRT_STAGES];
    logic [RTW+1:0]  n_rem  [SQRT_STAGES];
    logic [RTW-1:0]  n_root [SQRT_STAGES];

    always_comb begin
        logic [63:0]    rad;
        logic [RTW+1:0] rem;
        logic [RTW-1:0] root;
        logic [RTW+3:0] r2, t;
        for (int s = 0; s < SQRT_STAGES; s++) begin
            if (s == 0) begin
                rad  = {1'b0, i_sumsq};
                rem  = '0;
                root = '0;
            end else begin
                rad  = r_rad[s-1];
                rem  = r_rem[s-1];
                root = r_root[s-1];
            end
            for (int d = 0; d < 2; d++) begin
                r2  = {rem, rad[63:62]};
                t   = {2'b00, root, 2'b01};
                rad = {rad[61:0], 2'b00};
                if (r2 >= t) begin
                    rem  = (RTW+2)'(r2 - t);
                    root = {root[RTW-2:0], 1'b1};
                end else begin
                    rem  = (RTW+2)'(r2);
                    root = {root[RTW-2:0], 1'b0};
                end
            end
            n_rad[s]  = rad;
            n_rem[s]  = rem;
            n_root[s] = root;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[SQRT_STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < SQRT_STAGES; s++) begin
                r_rad[s]  <= n_rad[s];
                r_rem[s]  <= n_rem[s];
                r_root[s] <= n_root[s];
                r_mag[s]  <= (s == 0) ? i_mag : r_mag[(s == 0) ? 0 : s-1];
                r_ctl[s]  <= (s == 0) ? i_ctl : r_ctl[(s == 0) ? 0 : s-1];
            end
        end
    end

    assign o_valid = r_v[SQRT_STAGES-1];
    assign o_ctl   = r_ctl[SQRT_STAGES-1];
    assign o_mag   = r_mag[SQRT_STAGES-1];
    assign o_root  = r_root[SQRT_STAGES-1];

endmodule

### rtl/qpn_div.sv
// Four-lane pipelined rounding divider, one quotient bit per stage, and sign.
module qpn_div (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  qpn_pkg::t_ctl i_ctl,
    input  qpn_pkg::t_mags i_mag,
    input  logic [qpn_pkg::RTW-1:0] i_root,
    output logic          o_valid,
    output qpn_pkg::t_res o_res
);
    import qpn_pkg::*;

    // dividend stage
    logic             r_v0;
    logic [NUMW-1:0]  r_num [4];
    logic [RTW-1:0]   r_den0;
    t_ctl             r_ctl0;

    logic [DIV_STAGES-1:0] r_v;
    logic [RTW-1:0]   r_rem [DIV_STAGES][4];
    logic [QTW-1:0]   r_low [DIV_STAGES][4];
    logic [QTW-1:0]   r_q   [DIV_STAGES][4];
    logic [RTW-1:0]   r_den [DIV_STAGES];
    t_ctl             r_ctl [DIV_STAGES];

    logic [RTW-1:0]   n_rem [DIV_STAGES][4];
    logic [QTW-1:0]   n_low [DIV_STAGES][4];
    logic [QTW-1:0]   n_q   [DIV_STAGES][4];

    logic [QTW-1:0]   fq;
    t_ctl             fctl;

    always_comb begin
        logic [RTW-1:0] rem, den;
        logic [QTW-1:0] low, q;
        logic [RTW:0]   t;
        for (int s = 0; s < DIV_STAGES; s++) begin
            for (int l = 0; l < 4; l++) begin
                if (s == 0) begin
                    rem = RTW'(r_num[l][NUMW-1:QTW]);
                    low = r_num[l][QTW-1:0];
                    q   = '0;
                    den = r_den0;
                end else begin
                    rem = r_rem[s-1][l];
                    low = r_low[s-1][l];
                    q   = r_q[s-1][l];
                    den = r_den[s-1];
                end
                t = {rem, low[QTW-1]};
                if (t >= {1'b0, den}) begin
                    n_rem[s][l] = RTW'(t - {1'b0, den});
                    n_q[s][l]   = {q[QTW-2:0], 1'b1};
                end else begin
                    n_rem[s][l] = RTW'(t);
                    n_q[s][l]   = {q[QTW-2:0], 1'b0};
                end
                n_low[s][l] = {low[QTW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v  <= '0;
        end else if (i_en) begin
            r_v0 <= i_valid;
            r_v  <= {r_v[DIV_STAGES-2:0], r_v0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < 4; l++) begin
                r_num[l] <= NUMW'({i_mag[l], 14'd0}) + NUMW'(i_root[RTW-1:1]);
            end
            r_den0 <= i_root;
            r_ctl0 <= i_ctl;
            for (int s = 0; s < DIV_STAGES; s++) begin
                r_rem[s] <= n_rem[s];
                r_low[s] <= n_low[s];
                r_q[s]   <= n_q[s];
                r_den[s] <= (s == 0) ? r_den0 : r_den[(s == 0) ? 0 : s-1];
                r_ctl[s] <= (s == 0) ? r_ctl0 : r_ctl[(s == 0) ? 0 : s-1];
            end
        end
    end

    // Zero norm and the unused command both force an all-zero result.
    always_comb begin
        fctl = r_ctl[DIV_STAGES-1];
        for (int l = 0; l < 4; l++) begin
            fq = r_q[DIV_STAGES-1][l];
            if (fctl.zero || fctl.blank) begin
                o_res.r[l] = '0;
            end else if (fctl.neg[l]) begin
                o_res.r[l] = QW'(-{1'b0, fq});
            end else begin
                o_res.r[l] = QW'(fq);
            end
        end
        o_res.zero_norm = fctl.zero & ~fctl.blank;
    end

    assign o_valid = r_v[DIV_STAGES-1];

endmodule

### test/quaternion_product_normalized_core_test.sv
// Self-checking testbench of the normalized quaternion product core.
`timescale 1ns / 100ps

module quaternion_product_normalized_core_test;
    import qpn_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]         cmd;
        logic signed [15:0] q [8];
    } t_item;

    typedef struct {
        logic [15:0] c [4];
        logic        zn;
    } t_unit;

    // Scoreboard: predicts the unit quaternion of each accepted beat and keeps it in order.
    class unit_quat_board;
        t_unit pending[$];
        int    mismatches;

        function automatic longint unsigned root64(longint unsigned v);
            longint unsigned res, bit_v;
            res = 0;
            bit_v = 64'd1 << 62;
            while (bit_v > v) bit_v >>= 2;
            while (bit_v != 0) begin
                if (v >= res + bit_v) begin
                    v -= res + bit_v;
                    res = (res >> 1) + bit_v;
                end else begin
                    res >>= 1;
                end
                bit_v >>= 2;
            end
            return res;
        endfunction

        function automatic t_unit normalize(t_item it);
            longint ax, ay, az, aw, bx, by, bz, bw;
            longint r [4];
            longint unsigned mag [4];
            longint unsigned m, s, n, o;
            t_unit u;
            ax = it.q[0]; ay = it.q[1]; az = it.q[2]; aw = it.q[3];
            bx = it.q[4]; by = it.q[5]; bz = it.q[6]; bw = it.q[7];
            for (int i = 0; i < 4; i++) u.c[i] = '0;
            u.zn = 1'b0;
            case (it.cmd)
                CMD_MUL: begin
                    r[0] = ax*bw + ay*bz - az*by + aw*bx;
                    r[1] = -ax*bz + ay*bw + az*bx + aw*by;
                    r[2] = ax*by - ay*bx + az*bw + aw*bz;
                    r[3] = -ax*bx - ay*by - az*bz + aw*bw;
                end
                CMD_CONJ: begin
                    r[0] = ax*bw - ay*bz + az*by - aw*bx;
                    r[1] = ax*bz + ay*bw - az*bx - aw*by;
                    r[2] = -ax*by + ay*bx + az*bw - aw*bz;
                    r[3] = ax*bx + ay*by + az*bz + aw*bw;
                end
                CMD_YAW: begin
                    r[0] = 0; r[1] = 0; r[2] = az; r[3] = aw;
                end
                default: return u;
            endcase
            m = 0;
            for (int i = 0; i < 4; i++) begin
                mag[i] = (r[i] < 0) ? -r[i] : r[i];
                if (mag[i] > m) m = mag[i];
            end
            if (m == 0) begin
                u.zn = 1'b1;
                return u;
            end
            while (m > (64'd1 << 30)) begin
                m >>= 1;
                for (int i = 0; i < 4; i++) mag[i] >>= 1;
            end
            while (m < (64'd1 << 29)) begin
                m <<= 1;
                for (int i = 0; i < 4; i++) mag[i] <<= 1;
            end
            s = 0;
            for (int i = 0; i < 4; i++) s += mag[i] * mag[i];
            n = root64(s);
            for (int i = 0; i < 4; i++) begin
                o = (mag[i] * 16384 + (n >> 1)) / n;
                u.c[i] = (r[i] < 0) ? -o[15:0] : o[15:0];
            end
            return u;
        endfunction

        function void note_input(t_item it);
            pending.push_back(normalize(it));
        endfunction

        function void check_result(t_unit got);
            t_unit want;
            bit bad;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("result beat with nothing expected");
                return;
            end
            want = pending.pop_front();
            bad = (want.zn !== got.zn);
            for (int i = 0; i < 4; i++) if (want.c[i] !== got.c[i]) bad = 1;
            if (bad) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %h %h %h %h zn %b, got %h %h %h %h zn %b",
                             want.c[0], want.c[1], want.c[2], want.c[3], want.zn,
                             got.c[0], got.c[1], got.c[2], got.c[3], got.zn);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    logic o_ready, o_valid, o_zero_norm;
    logic [1:0] i_command = '0;
    logic signed [15:0] i_a_x = '0, i_a_y = '0, i_a_z = '0, i_a_w = '0;
    logic signed [15:0] i_b_x = '0, i_b_y = '0, i_b_z = '0, i_b_w = '0;
    logic signed [15:0] o_r_x, o_r_y, o_r_z, o_r_w;

    unit_quat_board board = new();
    int send_idle_pct = 30;
    int recv_idle_pct = 56;
    bit hold_receiver = 1'b0;

    quaternion_product_normalized_core dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Accepted beats are noted on the same edge they are taken.
    always @(posedge i_clk) begin
        t_item it;
        t_unit got;
        if (i_rst_n && i_valid && o_ready) begin
            it.cmd = i_command;
            it.q[0] = i_a_x; it.q[1] = i_a_y; it.q[2] = i_a_z; it.q[3] = i_a_w;
            it.q[4] = i_b_x; it.q[5] = i_b_y; it.q[6] = i_b_z; it.q[7] = i_b_w;
            board.note_input(it);
        end
        if (i_rst_n && o_valid && i_ready) begin
            got.c[0] = o_r_x; got.c[1] = o_r_y; got.c[2] = o_r_z; got.c[3] = o_r_w;
            got.zn = o_zero_norm;
            board.check_result(got);
        end
    end

    // Receiver readiness, with one long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) i_ready <= 1'b0;
        else if (hold_receiver) i_ready <= 1'b0;
        else i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Valid stays high between back-to-back beats and drops only in idle cycles.
    task automatic send_item(t_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_command <= it.cmd;
        i_a_x <= it.q[0]; i_a_y <= it.q[1]; i_a_z <= it.q[2]; i_a_w <= it.q[3];
        i_b_x <= it.q[4]; i_b_y <= it.q[5]; i_b_z <= it.q[6]; i_b_w <= it.q[7];
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] pick_component();
        case ($urandom_range(5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sh0000;
            3: return $signed(16'($urandom_range(32))) - 16;
            4: return $urandom_range(1) ? 16'sh4000 : 16'shc000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_item random_item();
        t_item it;
        it.cmd = ($urandom_range(19) == 0) ? CMD_UNUSED : 2'($urandom_range(2));
        for (int k = 0; k < 8; k++)
            it.q[k] = ($urandom_range(3) == 0) ? pick_component() : 16'($urandom);
        // Zeroing all of quaternion a gives a zero product.
        if ($urandom_range(9) == 0) for (int k = 0; k < 4; k++) it.q[k] = 0;
        return it;
    endfunction

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        t_item it;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, every command, zero norm, unused command, tiny values.
        for (int c = 0; c < 4; c++) begin
            it.cmd = 2'(c);
            for (int k = 0; k < 8; k++) it.q[k] = 16'sh8000;
            send_item(it);
            for (int k = 0; k < 8; k++) it.q[k] = 16'sh7fff;
            send_item(it);
            for (int k = 0; k < 8; k++) it.q[k] = 0;
            send_item(it);
            for (int k = 0; k < 8; k++) it.q[k] = (k == 3 || k == 7) ? 16'sh4000 : 0;
            send_item(it);
            for (int k = 0; k < 8; k++)
                it.q[k] = (k == 1) ? 16'sh0001 : (((k & 1) != 0) ? 16'shffff : 16'sh0000);
            send_item(it);
        end
        it.cmd = CMD_YAW;
        for (int k = 0; k < 8; k++) it.q[k] = (k == 0 || k == 1) ? 16'sh7fff : 0;
        send_item(it);

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 30 : (ph == 1) ? 56 : 0;
            recv_idle_pct = (ph == 0) ? 56 : (ph == 1) ? 30 : 0;
            for (int n = 0; n < 520; n++) begin
                if (ph == 0 && n == 100) begin
                    hold_receiver = 1'b1;
                    fork
                        begin
                            repeat (150) @(posedge i_clk);
                            hold_receiver = 1'b0;
                        end
                    join_none
                end
                // Sender pause until everything has come back.
                if (ph == 1 && n == 260) wait_drained();
                send_item(random_item());
            end
        end
        wait_drained();
        repeat (60) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #4ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
